>>> sv/sha256s_pkg.sv
package sha256s_pkg;

   typedef logic [31:0] word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_PAD,
      ST_EMIT
   } state_type;

   localparam logic [7:0] PAD_MARK  = 8'h80;
   localparam logic [5:0] LEN_START = 6'd56;
   localparam logic [5:0] FILL_LAST = 6'd63;
   localparam logic [5:0] ROUND_LAST = 6'd63;
   localparam logic [2:0] WORD_LAST = 3'd7;

   localparam word_type INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic word_type big_sigma0(word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic word_type big_sigma1(word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic word_type small_sigma0(word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic word_type small_sigma1(word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

>>> sv/sha256s_req_if.sv
interface sha256s_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       message_end;

   modport source (output valid, data_byte, byte_valid, message_end, input ready);
   modport sink   (input valid, data_byte, byte_valid, message_end, output ready);
endinterface

>>> sv/sha256s_rsp_if.sv
interface sha256s_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

>>> sv/sha256_stream_hasher.sv
// channel | dir | payload                                 | handshake
// req_chan | in  | data_byte[8], byte_valid, message_end    | valid/ready
// rsp_chan | out | digest_word[32], word_index[3], last_word | valid/ready
//
// One request is taken per cycle while a block is filling.
// Each 64th byte starts the round unit, which runs all its rounds and then folds
// into the hash; the block takes no request meanwhile.
// A message end pads one byte a cycle between block runs (one or two block runs),
// then offers eight digest words, one per cycle while rsp_chan.ready is high.
// Synchronous reset loads the initial hash and clears fill and length.
module sha256_stream_hasher
   import sha256s_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   sha256s_req_if.sink          req_chan,
   sha256s_rsp_if.source        rsp_chan
);

   state_type   state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;
   logic [60:0] len_ff, len_in;
   logic [5:0]  round_ff, round_in;
   logic [2:0]  idx_ff, idx_in;
   logic        pad_active_ff, pad_active_in;
   logic        pad_first_ff, pad_first_in;
   logic        len_phase_ff, len_phase_in;
   logic        emit_ff, emit_in;
   word_type    hash_ff [8];
   word_type    hash_in [8];
   logic [23:0] assem_ff, assem_in;
   word_type    sched_ff [16];
   word_type    sched_in [16];
   word_type    vars_ff [8];
   word_type    vars_in [8];

   logic        push_en;
   logic [7:0]  push_byte;
   logic        load_vars;
   logic [63:0] len_bits;
   word_type    t1, t2, sched_new, ch, maj;

   assign len_bits  = {len_ff, 3'b000};
   assign ch        = (vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]);
   assign maj       = (vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
                      ^ (vars_ff[1] & vars_ff[2]);
   assign t1        = vars_ff[7] + big_sigma1(vars_ff[4]) + ch + ROUND_K[round_ff]
                      + sched_ff[0];
   assign t2        = big_sigma0(vars_ff[0]) + maj;
   assign sched_new = small_sigma1(sched_ff[14]) + sched_ff[9]
                      + small_sigma0(sched_ff[1]) + sched_ff[0];

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = (state_ff == ST_EMIT);
   assign rsp_chan.digest_word = hash_ff[idx_ff];
   assign rsp_chan.word_index  = idx_ff;
   assign rsp_chan.last_word   = (idx_ff == WORD_LAST);

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      len_in        = len_ff;
      round_in      = round_ff;
      idx_in        = idx_ff;
      pad_active_in = pad_active_ff;
      pad_first_in  = pad_first_ff;
      len_phase_in  = len_phase_ff;
      emit_in       = emit_ff;
      hash_in       = hash_ff;
      assem_in      = assem_ff;
      sched_in      = sched_ff;
      vars_in       = vars_ff;
      push_en       = 1'b0;
      push_byte     = req_chan.data_byte;
      load_vars     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.byte_valid) begin
                  push_en = 1'b1;
                  len_in  = len_ff + 61'd1;
               end
               if (req_chan.message_end) begin
                  pad_active_in = 1'b1;
                  pad_first_in  = 1'b1;
                  state_in      = ST_PAD;
               end
               if (req_chan.byte_valid && fill_ff == FILL_LAST) begin
                  load_vars = 1'b1;
                  state_in  = ST_ROUND;
               end
            end
         end
         ST_PAD: begin
            push_en = 1'b1;
            if (pad_first_ff) begin
               push_byte    = PAD_MARK;
               pad_first_in = 1'b0;
            end else if (len_phase_ff || fill_ff == LEN_START) begin
               push_byte    = len_bits[{~fill_ff[2:0], 3'b000} +: 8];
               len_phase_in = 1'b1;
               if (fill_ff == FILL_LAST) begin
                  len_phase_in  = 1'b0;
                  pad_active_in = 1'b0;
                  emit_in       = 1'b1;
               end
            end else begin
               push_byte = 8'h00;
            end
            if (fill_ff == FILL_LAST) begin
               load_vars = 1'b1;
               state_in  = ST_ROUND;
            end
         end
         ST_ROUND: begin
            for (int i = 0; i < 15; i++) begin
               sched_in[i] = sched_ff[i + 1];
            end
            sched_in[15] = sched_new;
            vars_in[7] = vars_ff[6];
            vars_in[6] = vars_ff[5];
            vars_in[5] = vars_ff[4];
            vars_in[4] = vars_ff[3] + t1;
            vars_in[3] = vars_ff[2];
            vars_in[2] = vars_ff[1];
            vars_in[1] = vars_ff[0];
            vars_in[0] = t1 + t2;
            round_in   = round_ff + 6'd1;
            if (round_ff == ROUND_LAST) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            for (int i = 0; i < 8; i++) begin
               hash_in[i] = hash_ff[i] + vars_ff[i];
            end
            if (emit_ff) begin
               idx_in   = 3'd0;
               state_in = ST_EMIT;
            end else if (pad_active_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (rsp_chan.ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == WORD_LAST) begin
                  hash_in  = INIT_HASH;
                  len_in   = '0;
                  emit_in  = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (push_en) begin
         assem_in = {assem_ff[15:0], push_byte};
         fill_in  = fill_ff + 6'd1;
         if (fill_ff[1:0] == 2'b11) begin
            for (int i = 0; i < 15; i++) begin
               sched_in[i] = sched_ff[i + 1];
            end
            sched_in[15] = {assem_ff, push_byte};
         end
      end

      if (load_vars) begin
         vars_in  = hash_ff;
         round_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         len_ff        <= '0;
         round_ff      <= '0;
         idx_ff        <= '0;
         pad_active_ff <= 1'b0;
         pad_first_ff  <= 1'b0;
         len_phase_ff  <= 1'b0;
         emit_ff       <= 1'b0;
         hash_ff       <= INIT_HASH;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         len_ff        <= len_in;
         round_ff      <= round_in;
         idx_ff        <= idx_in;
         pad_active_ff <= pad_active_in;
         pad_first_ff  <= pad_first_in;
         len_phase_ff  <= len_phase_in;
         emit_ff       <= emit_in;
         hash_ff       <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      assem_ff <= assem_in;
      sched_ff <= sched_in;
      vars_ff  <= vars_in;
   end

endmodule

>>> bench/tb_sha256_stream_hasher.sv
`timescale 1ns / 100ps

module tb_sha256_stream_hasher;

   localparam int        CYCLE_LIMIT  = 400000;
   localparam int        TAIL_CYCLES  = 200;
   localparam int        PRINT_LIMIT  = 40;
   localparam logic [7:0] PAD_BYTE    = 8'h80;
   localparam logic [5:0] LENGTH_SLOT = 6'd56;
   localparam logic [2:0] FINAL_INDEX = 3'd7;

   localparam logic [31:0] SHA_IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] SHA_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   typedef struct {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_entry_type;

   logic clock = 1'b0;
   logic reset;

   sha256s_req_if req_chan();
   sha256s_rsp_if rsp_chan();

   sha256_stream_hasher DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // running hash state
   logic [31:0] hash_chain [8];
   logic [7:0]  hash_block [64];
   logic [5:0]  hash_fill;
   logic [60:0] hash_len_bytes;

   digest_entry_type expected_digests [$];

   int mismatch_count  = 0;
   int digests_checked = 0;
   int items_sent      = 0;
   int messages_closed = 0;
   int cycle_count     = 0;
   int rsp_hold_cycles = 0;
   bit quiet_mode      = 1'b0;

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_LIMIT)
         $display("[%0t] mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void hash_restart();
      hash_chain     = SHA_IV;
      hash_fill      = '0;
      hash_len_bytes = '0;
   endfunction

   function automatic void hash_compress();
      logic [31:0] sched [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int i = 0; i < 16; i++)
         sched[i] = {hash_block[4*i], hash_block[4*i+1], hash_block[4*i+2], hash_block[4*i+3]};
      for (int i = 16; i < 64; i++) begin
         s0 = rotr32(sched[i-15], 7) ^ rotr32(sched[i-15], 18) ^ (sched[i-15] >> 3);
         s1 = rotr32(sched[i-2], 17) ^ rotr32(sched[i-2], 19) ^ (sched[i-2] >> 10);
         sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
      end
      a = hash_chain[0]; b = hash_chain[1]; c = hash_chain[2]; d = hash_chain[3];
      e = hash_chain[4]; f = hash_chain[5]; g = hash_chain[6]; h = hash_chain[7];
      for (int r = 0; r < 64; r++) begin
         t1 = h + (rotr32(e, 6) ^ rotr32(e, 11) ^ rotr32(e, 25)) + ((e & f) ^ (~e & g))
              + SHA_K[r] + sched[r];
         t2 = (rotr32(a, 2) ^ rotr32(a, 13) ^ rotr32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      hash_chain[0] += a; hash_chain[1] += b; hash_chain[2] += c; hash_chain[3] += d;
      hash_chain[4] += e; hash_chain[5] += f; hash_chain[6] += g; hash_chain[7] += h;
   endfunction

   function automatic void hash_absorb_byte(input logic [7:0] value);
      hash_block[hash_fill] = value;
      hash_fill++;
      if (hash_fill == 6'd0)
         hash_compress();
   endfunction

   // update the running hash with one accepted request; queue the digest on message end
   function automatic void predict_digest(input logic [7:0] data, input logic byte_ok,
                                          input logic last_req);
      logic [63:0] bit_len;
      if (byte_ok) begin
         hash_len_bytes++;
         hash_absorb_byte(data);
      end
      if (!last_req)
         return;
      bit_len = {hash_len_bytes, 3'b000};
      hash_absorb_byte(PAD_BYTE);
      while (hash_fill != LENGTH_SLOT)
         hash_absorb_byte(8'h00);
      for (int i = 0; i < 8; i++)
         hash_absorb_byte(bit_len[63 - 8*i -: 8]);
      for (int i = 0; i < 8; i++)
         expected_digests.push_back('{hash_chain[i], 3'(i), 3'(i) == FINAL_INDEX});
      hash_restart();
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return $urandom_range(1, 2);
      else if (r < 92)
         return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_request(input logic [7:0] data, input logic byte_ok,
                               input logic last_req);
      int gap;
      gap = (quiet_mode || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.data_byte   <= data;
      req_chan.byte_valid  <= byte_ok;
      req_chan.message_end <= last_req;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      predict_digest(data, byte_ok, last_req);
      if (byte_ok || last_req)
         items_sent++;
      if (last_req)
         messages_closed++;
   endtask

   task automatic send_message(input int len, input bit end_empty);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0)
            send_request(8'($urandom), 1'b0, 1'b0);
         send_request(8'($urandom), 1'b1, (i == len - 1) && !end_empty);
      end
      if (len == 0 || end_empty)
         send_request(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic wait_for_digests();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (expected_digests.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_directed_cases();
      send_request(8'h00, 1'b0, 1'b1);   // empty message
      send_request(8'hff, 1'b0, 1'b0);   // idle request, ignored
      send_request(8'h61, 1'b1, 1'b0);
      send_request(8'h62, 1'b1, 1'b0);
      send_request(8'h63, 1'b1, 1'b1);
      send_request(8'hff, 1'b1, 1'b1);
      send_request(8'h00, 1'b1, 1'b1);
      send_request(8'h80, 1'b1, 1'b0);
      send_request(8'h7f, 1'b1, 1'b0);
      send_request(8'h55, 1'b0, 1'b0);
      send_request(8'haa, 1'b0, 1'b1);   // empty end after data, byte ignored
      wait_for_digests();
   endtask

   // length field pushed into a second block, and a message ending on a whole block
   task automatic test_block_boundaries();
      send_message(56, 1'b1);
      send_message(64, 1'b0);
      wait_for_digests();
   endtask

   task automatic test_output_backpressure();
      @(posedge clock);
      rsp_hold_cycles = 400;
      quiet_mode = 1'b1;
      send_message(5, 1'b0);
      send_message(8, 1'b0);
      quiet_mode = 1'b0;
      wait_for_digests();
   endtask

   task automatic test_random_messages();
      int target;
      int len;
      target = items_sent + 20;
      while (items_sent < target) begin
         quiet_mode = ($urandom_range(0, 4) == 0);
         len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 12) : $urandom_range(13, 30);
         send_message(len, $urandom_range(0, 3) == 0);
      end
      quiet_mode = 1'b0;
      wait_for_digests();
   endtask

   // receiver: random stalls plus an optional long hold-off
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_chan.ready <= 1'b0;
            rsp_hold_cycles--;
         end else if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (!quiet_mode && $urandom_range(0, 3) == 0)
               stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      digest_entry_type next_word;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (expected_digests.size() == 0) begin
            report_mismatch($sformatf("digest word %08h with none pending",
                                      rsp_chan.digest_word));
         end else begin
            next_word = expected_digests.pop_front();
            digests_checked++;
            if (rsp_chan.digest_word !== next_word.word)
               report_mismatch($sformatf("digest_word %08h, predicted %08h",
                                         rsp_chan.digest_word, next_word.word));
            if (rsp_chan.word_index !== next_word.index)
               report_mismatch($sformatf("word_index %0d, predicted %0d",
                                         rsp_chan.word_index, next_word.index));
            if (rsp_chan.last_word !== next_word.last)
               report_mismatch($sformatf("last_word %0b, predicted %0b",
                                         rsp_chan.last_word, next_word.last));
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d digest words outstanding",
               cycle_count, expected_digests.size());
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.data_byte   = 8'h00;
      req_chan.byte_valid  = 1'b0;
      req_chan.message_end = 1'b0;
      hash_restart();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_block_boundaries();
      test_output_backpressure();
      test_random_messages();

      wait_for_digests();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Hashed %0d messages from %0d byte and end requests; %0d digest words checked.",
               messages_closed, items_sent, digests_checked);
      $display("Covered empty messages, idle requests, pad boundaries and output hold-off.");
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
